/* sv/q8bdp_pkg.sv */
// Package for the Q8_0 block dot-product unit: shared constants, queue entry type and
// IEEE half/single helper functions. No dependencies.
`default_nettype none
package q8bdp_pkg;

    localparam int BlockLen = 32;
    localparam int Lanes    = 4;
    localparam int SumBits  = 21;
    localparam logic [31:0] CanonNan = 32'h7FC0_0000;

    // One closed block handed from the front part to the back part.
    typedef struct packed {
        logic signed [SumBits-1:0] sum;
        logic [15:0]               act_scale;
        logic [15:0]               wgt_scale;
        logic                      row_end;
    } blk_t;

    // Unpacked single operand: value = (-1)^sign * mant * 2^(exp-150).
    typedef struct packed {
        logic        sign;
        logic        is_inf;
        logic        is_nan;
        logic [9:0]  exp;
        logic [23:0] mant;
    } fop_t;

    // Exact widening of an IEEE half to IEEE single.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [7:0]  e32;
        logic [31:0] r;
        e = h[14:10];
        m = h[9:0];
        r = {h[15], 31'd0};
        if (e == 5'd0) begin
            if (m != 10'd0) begin
                e32 = 8'd112;
                for (int i = 0; i < 10; i++) begin
                    if (!m[9]) begin
                        m   = {m[8:0], 1'b0};
                        e32 = e32 - 8'd1;
                    end
                end
                // one more shift moves the leading one out of the field
                m = {m[8:0], 1'b0};
                r = {h[15], e32, m, 13'd0};
            end
        end else if (e == 5'd31) begin
            r = {h[15], 8'hFF, h[9:0], 13'd0};
        end else begin
            r = {h[15], 8'(e) + 8'd112, h[9:0], 13'd0};
        end
        return r;
    endfunction

    function automatic fop_t unpack_single(input logic [31:0] b);
        fop_t o;
        o.sign   = b[31];
        o.is_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        o.is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        o.exp    = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
        o.mant   = {(b[30:23] != 8'd0), b[22:0]};
        return o;
    endfunction

    // Round an unsigned 50-bit magnitude to single, nearest even.
    // Value = mag * 2^(e0 - 150), with e0 signed and possibly low.
    function automatic logic [31:0] round_pack(input logic sign, input logic [49:0] mag,
                                               input logic signed [11:0] e0);
        logic [5:0]         lz;
        logic               found;
        logic signed [11:0] ebit;
        logic signed [11:0] sh;
        logic [49:0]        kept;
        logic               rbit;
        logic               sticky;
        logic [24:0]        m;
        logic [49:0]        msk;
        logic [31:0]        r;
        lz    = 6'd0;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found && mag[i]) begin
                found = 1'b1;
                lz    = 6'(49 - i);
            end
        end
        r = {sign, 31'd0};
        if (found) begin
            // exponent of leading bit as biased single exponent
            ebit = e0 + 12'sd26 - 12'(lz);
            // right shift so the leading bit lands at position 23
            sh = 12'sd26 - 12'(lz);
            if (ebit < 12'sd1) begin
                sh = sh + (12'sd1 - ebit);
                ebit = 12'sd0;
            end
            if (sh > 12'sd50) begin
                kept = 50'd0; rbit = 1'b0; sticky = 1'b1;
            end else if (sh > 12'sd0) begin
                kept   = mag >> sh;
                rbit   = mag[sh-1];
                msk    = (50'd1 << (sh - 1)) - 50'd1;
                sticky = |(mag & msk);
            end else begin
                kept = mag << (-sh); rbit = 1'b0; sticky = 1'b0;
            end
            m = {1'b0, kept[23:0]} + 25'(rbit & (sticky | kept[0]));
            if (ebit == 12'sd0) begin
                // subnormal: carry into bit 23 makes it normal
                r = {sign, 7'd0, m[23], m[22:0]};
            end else begin
                if (m[24]) begin
                    ebit = ebit + 12'sd1;
                    m    = m >> 1;
                end
                if (ebit >= 12'sd255) r = {sign, 8'hFF, 23'd0};
                else                  r = {sign, ebit[7:0], m[22:0]};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/q8bdp_front.sv */
// Front part: sums the int8 products of each request and closes blocks.
// Depends on q8bdp_pkg.
`default_nettype none
module q8bdp_front (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic signed [q8bdp_pkg::Lanes-1:0][7:0]   act,
    input  wire logic signed [q8bdp_pkg::Lanes-1:0][7:0]   wgt,
    input  wire logic [15:0]                               act_scale,
    input  wire logic [15:0]                               wgt_scale,
    input  wire logic                                      block_end,
    input  wire logic                                      row_end,
    input  wire logic                                      in_valid,
    output      logic                                      in_ready,
    output      q8bdp_pkg::blk_t                           blk,
    output      logic                                      blk_valid,
    input  wire logic                                      blk_ready
);
    import q8bdp_pkg::*;

    logic signed [SumBits-1:0] sum_reg, sum_next;
    logic signed [SumBits-1:0] total;
    logic                      fire;

    // Adder tree over all lanes of this request.
    always_comb
    begin
        total = sum_reg;
        for (int i = 0; i < Lanes; i++) begin
            total = total + SumBits'($signed(act[i]) * $signed(wgt[i]));
        end
    end

    // A closing request needs room in the queue.
    assign in_ready  = blk_ready || !(block_end || row_end);
    assign fire      = in_valid && in_ready;
    assign blk_valid = in_valid && (block_end || row_end);
    assign blk.sum       = total;
    assign blk.act_scale = act_scale;
    assign blk.wgt_scale = wgt_scale;
    assign blk.row_end   = row_end;

    assign sum_next = !fire ? sum_reg : ((block_end || row_end) ? '0 : total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) sum_reg <= '0;
        else        sum_reg <= sum_next;
    end
endmodule
`default_nettype wire

/* sv/q8bdp_fifo.sv */
// Short queue of closed blocks between the front and back parts.
// Depends on q8bdp_pkg.
`default_nettype none
module q8bdp_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire q8bdp_pkg::blk_t wr_data,
    input  wire logic            wr_valid,
    output      logic            wr_ready,
    output      q8bdp_pkg::blk_t rd_data,
    output      logic            rd_valid,
    input  wire logic            rd_ready
);
    import q8bdp_pkg::*;

    blk_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    // Two-entry ring with an occupancy count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

/* sv/q8bdp_back.sv */
// Back part: scales each closed block and accumulates the row in IEEE single.
// Depends on q8bdp_pkg.
`default_nettype none
module q8bdp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire q8bdp_pkg::blk_t blk,
    input  wire logic            blk_valid,
    output      logic            blk_ready,
    output      logic [31:0]     row_sum,
    output      logic            out_valid,
    input  wire logic            out_ready
);
    import q8bdp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCALE, S_TERM, S_ADD, S_OUT} state_t;

    state_t                    state_reg;
    logic [31:0]               acc_reg;
    logic [31:0]               scale_reg;
    logic [31:0]               term_reg;
    logic signed [SumBits-1:0] sum_reg;
    logic                      row_reg;
    logic [15:0]               ascale_reg;
    logic [15:0]               wscale_reg;
    logic [31:0]               out_reg;
    logic                      ov_reg;

    fop_t        fa, fb, ft;
    logic [47:0] prod;
    logic [31:0] mul_res;
    logic [20:0] abs_sum;
    logic [31:0] add_res;
    logic [31:0] sa, sb;

    // Multiplier shared by the scale product and the term product.
    always_comb
    begin
        sa = half_to_single(wscale_reg);
        sb = half_to_single(ascale_reg);
        abs_sum = sum_reg[SumBits-1] ? 21'(-sum_reg) : 21'(sum_reg);
        if (state_reg == S_SCALE) begin
            fa = unpack_single(sa);
            fb = unpack_single(sb);
        end else begin
            fa = unpack_single(scale_reg);
            fb.sign = sum_reg[SumBits-1];
            fb.is_inf = 1'b0;
            fb.is_nan = 1'b0;
            fb.exp  = 10'd150;
            fb.mant = {3'd0, abs_sum};
        end
        prod = fa.mant * fb.mant;
        if (fa.is_nan || fb.is_nan)
            mul_res = CanonNan;
        else if (fa.is_inf || fb.is_inf) begin
            if ((!fa.is_inf && fa.mant == 24'd0) || (!fb.is_inf && fb.mant == 24'd0))
                mul_res = CanonNan;
            else
                mul_res = {fa.sign ^ fb.sign, 8'hFF, 23'd0};
        end else
            mul_res = round_pack(fa.sign ^ fb.sign, {2'b00, prod},
                                 12'($signed({2'b00, fa.exp}) + $signed({2'b00, fb.exp})) - 12'sd150);
    end

    // Adder for the row accumulator.
    always_comb
    begin
        logic [49:0] ma, mb, mr;
        logic [9:0]  ea, eb, d;
        logic        sr;
        ma = 50'd0;
        mb = 50'd0;
        mr = 50'd0;
        ea = 10'd0;
        eb = 10'd0;
        d  = 10'd0;
        sr = 1'b0;
        ft = unpack_single(term_reg);
        begin
            fop_t fx;
            fx = unpack_single(acc_reg);
            if (fx.is_nan || ft.is_nan)
                add_res = CanonNan;
            else if (fx.is_inf && ft.is_inf)
                add_res = (fx.sign == ft.sign) ? acc_reg : CanonNan;
            else if (fx.is_inf)
                add_res = acc_reg;
            else if (ft.is_inf)
                add_res = term_reg;
            else begin
                // One spare top bit keeps the carry of a same-sign sum.
                ea = fx.exp; eb = ft.exp;
                if (ea >= eb) begin
                    d  = ea - eb;
                    ma = {1'b0, fx.mant, 25'd0};
                    mb = (d > 10'd49) ? 50'(|ft.mant) : ({1'b0, ft.mant, 25'd0} >> d)
                         | 50'(|(({1'b0, ft.mant, 25'd0}) & ~({50{1'b1}} << d)) && d <= 10'd49);
                end else begin
                    d  = eb - ea;
                    ma = {1'b0, ft.mant, 25'd0};
                    mb = (d > 10'd49) ? 50'(|fx.mant) : ({1'b0, fx.mant, 25'd0} >> d)
                         | 50'(|(({1'b0, fx.mant, 25'd0}) & ~({50{1'b1}} << d)) && d <= 10'd49);
                end
                if (fx.sign == ft.sign) begin
                    mr = ma + mb; sr = fx.sign;
                end else if (ma >= mb) begin
                    mr = ma - mb; sr = (ea >= eb) ? fx.sign : ft.sign;
                end else begin
                    mr = mb - ma; sr = (ea >= eb) ? ft.sign : fx.sign;
                end
                if (mr == 50'd0)
                    add_res = {fx.sign & ft.sign, 31'd0};
                else
                    add_res = round_pack(sr, mr,
                        12'($signed({2'b00, (ea >= eb) ? ea : eb})) - 12'sd25);
            end
        end
    end

    assign blk_ready = (state_reg == S_IDLE);
    assign row_sum   = out_reg;
    assign out_valid = ov_reg;

    // Sequencer: scale product, term product, accumulate, then emit on row end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            acc_reg   <= 32'd0;
            out_reg   <= 32'd0;
            ov_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (blk_valid) state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_TERM;
                S_TERM: state_reg <= S_ADD;
                S_ADD: begin
                    acc_reg   <= add_res;
                    state_reg <= row_reg ? S_OUT : S_IDLE;
                end
                S_OUT: if (!ov_reg || out_ready) begin
                    out_reg   <= acc_reg;
                    acc_reg   <= 32'd0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            // The result register loads only once the previous row sum is taken.
            if (state_reg == S_OUT && (!ov_reg || out_ready)) ov_reg <= 1'b1;
            else if (out_ready)                                ov_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && blk_valid) begin
            sum_reg    <= blk.sum;
            row_reg    <= blk.row_end;
            ascale_reg <= blk.act_scale;
            wscale_reg <= blk.wgt_scale;
        end
        if (state_reg == S_SCALE) scale_reg <= mul_res;
        if (state_reg == S_TERM)  term_reg  <= mul_res;
    end
endmodule
`default_nettype wire

/* sv/q8_block_dot_product.sv */
// Top level of the Q8_0 block dot-product unit: front, queue and back parts.
// Depends on q8bdp_pkg, q8bdp_front, q8bdp_fifo, q8bdp_back.
//
// Usage: each input request carries four int8 activation/weight pairs, the
// two fp16 block scales and the block_end and row_end marks. Requests that do
// not close a block are taken one per cycle. A closing request enters a
// two-entry queue; the back part then takes one block at a time through
// accept, scale product, term product and accumulate steps, plus a result
// hand-off step for a block that ends a row, since it reuses one multiplier
// and a single accumulator. A row result appears on row_sum with out_valid
// once its block has been through these steps, and stays until the receiver
// takes it. While the receiver stalls, the queue fills and then in_ready
// falls for closing requests. Reset clears the block sum, the row
// accumulator (+0) and the queue.
`default_nettype none
module q8_block_dot_product (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic signed [7:0] act_0,
    input  wire logic signed [7:0] act_1,
    input  wire logic signed [7:0] act_2,
    input  wire logic signed [7:0] act_3,
    input  wire logic signed [7:0] wgt_0,
    input  wire logic signed [7:0] wgt_1,
    input  wire logic signed [7:0] wgt_2,
    input  wire logic signed [7:0] wgt_3,
    input  wire logic [15:0]       act_scale,
    input  wire logic [15:0]       wgt_scale,
    input  wire logic              block_end,
    input  wire logic              row_end,
    input  wire logic              in_valid,
    output      logic              in_ready,
    output      logic [31:0]       row_sum,
    output      logic              out_valid,
    input  wire logic              out_ready
);
    import q8bdp_pkg::*;

    logic signed [Lanes-1:0][7:0] act_v, wgt_v;
    blk_t q_wr, q_rd;
    logic q_wv, q_wr_rdy, q_rv, q_rd_rdy;

    assign act_v = {act_3, act_2, act_1, act_0};
    assign wgt_v = {wgt_3, wgt_2, wgt_1, wgt_0};

    q8bdp_front u_front (
        .clk, .rst_n, .act(act_v), .wgt(wgt_v), .act_scale, .wgt_scale,
        .block_end, .row_end, .in_valid, .in_ready,
        .blk(q_wr), .blk_valid(q_wv), .blk_ready(q_wr_rdy)
    );

    q8bdp_fifo u_fifo (
        .clk, .rst_n, .wr_data(q_wr), .wr_valid(q_wv), .wr_ready(q_wr_rdy),
        .rd_data(q_rd), .rd_valid(q_rv), .rd_ready(q_rd_rdy)
    );

    q8bdp_back u_back (
        .clk, .rst_n, .blk(q_rd), .blk_valid(q_rv), .blk_ready(q_rd_rdy),
        .row_sum, .out_valid, .out_ready
    );

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_sum))
        else $error("row result dropped while stalled");

    // Nothing enters the queue when it is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !q_wr_rdy |-> !(in_valid && in_ready && (block_end || row_end)))
        else $error("block queue overflow");
endmodule
`default_nettype wire
